@@ hw/rtl/forward_gradient_edge_map_macros.svh @@
// Assertion macros for the edge map checker.
// Used by fgem_checker.sv; no other dependencies.
`ifndef FORWARD_GRADIENT_EDGE_MAP_MACROS_SVH
`define FORWARD_GRADIENT_EDGE_MAP_MACROS_SVH

// a holds in the same cycle
`define FGEM_ASSERT_NOW(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
        else $error("fgem check failed");

// a implies b on the next edge
`define FGEM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fgem check failed");

`endif

@@ hw/rtl/fgem_pkg.sv @@
// Shared types and constants for the forward gradient edge map.
// No dependencies; imported by every module of the block but fgem_queue.
`default_nettype none

package fgem_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 13;
    localparam int WIDTH_REG_W = 12;
    localparam int HGT_W       = 13;
    localparam int ROW_W       = 12;
    localparam int JOBQ_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0]       HEIGHT_RESET = 13'd480;
    localparam logic [HGT_W-1:0]       HEIGHT_LIMIT = 13'd4096;

    typedef struct packed {
        logic has_up;
        logic last_row;
        logic has_right;
        logic self_rd;
    } job_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/forward_gradient_edge_map.sv @@
// Top level of the forward gradient edge map: front, job queue and back.
// Depends on fgem_pkg, fgem_front, fgem_queue and fgem_back.
//
//   port group   direction   handshake          payload
//   input        in          push / full        sample
//   result       out         empty / pop        edge_value, pixel_row, pixel_col,
//                                               last_of_run
//   config       in          cfg_we             cfg_index, cfg_data
//
// One item per clock is accepted while the queue is not full; it is registered
// in the job queue, then in the back end. Items of the last row below the first
// give two results each; the back end takes no new item until both are popped.
// The line buffer is one memory with one read and one write per item.
// Reset clears counters and queues at once; the line buffer is not cleared.
// Either side may stall; the four-entry job queue lets the other run on.
`default_nettype none

module forward_gradient_edge_map #(
    parameter int   MAX_WIDTH   = 2048,
    parameter int   SAMPLE_BITS = 16,
    localparam int  COL_W       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [SAMPLE_BITS-1:0]         sample,
    output logic                           empty,
    input  logic                           pop,
    output logic [SAMPLE_BITS:0]           edge_value,
    output logic [fgem_pkg::ROW_W-1:0]     pixel_row,
    output logic [COL_W-1:0]               pixel_col,
    output logic                           last_of_run,
    input  logic                           cfg_we,
    input  logic [fgem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fgem_pkg::CFG_W-1:0]     cfg_data
);

    import fgem_pkg::*;

    localparam int CTL_W = $bits(job_ctl_t);
    localparam int JOB_W = CTL_W + SAMPLE_BITS + ROW_W + 2 * COL_W;

    logic                   f_push;
    job_ctl_t               f_ctl;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [ROW_W-1:0]       f_row;
    logic [COL_W-1:0]       f_col, f_addr;
    logic [JOB_W-1:0]       q_wdata, q_rdata;
    logic                   q_full, q_empty, q_pop;
    job_ctl_t               b_ctl;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic [ROW_W-1:0]       b_row;
    logic [COL_W-1:0]       b_col, b_addr;

    assign full    = q_full;
    assign q_wdata = {f_ctl, f_sample, f_row, f_col, f_addr};
    assign {b_ctl, b_sample, b_row, b_col, b_addr} = q_rdata;

    fgem_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_W       (COL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .sample     (sample),
        .q_full     (q_full),
        .job_push   (f_push),
        .job_ctl    (f_ctl),
        .job_sample (f_sample),
        .job_row    (f_row),
        .job_col    (f_col),
        .job_addr   (f_addr)
    );

    fgem_queue #(
        .W     (JOB_W),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    fgem_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_W       (COL_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!q_empty),
        .job_pop     (q_pop),
        .job_ctl     (b_ctl),
        .job_sample  (b_sample),
        .job_row     (b_row),
        .job_col     (b_col),
        .job_addr    (b_addr),
        .empty       (empty),
        .pop         (pop),
        .edge_value  (edge_value),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

@@ hw/rtl/fgem_queue.sv @@
// Small register FIFO for the job queue between front and back.
// Generic over width and depth; uses no package items.
`default_nettype none

module fgem_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  slot_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fgem_front.sv @@
// Front end: configuration registers, raster counters and job classification.
// Depends on fgem_pkg; feeds the job queue.
`default_nettype none

module fgem_front #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W       = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fgem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fgem_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           push,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  logic                           q_full,
    output logic                           job_push,
    output fgem_pkg::job_ctl_t             job_ctl,
    output logic [SAMPLE_BITS-1:0]         job_sample,
    output logic [fgem_pkg::ROW_W-1:0]     job_row,
    output logic [COL_W-1:0]               job_col,
    output logic [COL_W-1:0]               job_addr
);

    import fgem_pkg::*;

    localparam int CNT_W = COL_W + 1;

    logic [WIDTH_REG_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0]       height_reg, height_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [31:0]            w_ext, w_clamp;
    logic [CNT_W-1:0]       w_eff;
    logic [HGT_W-1:0]       h_eff;
    logic                   c_last, last_row, accept;

    assign w_ext   = {{(32-WIDTH_REG_W){1'b0}}, width_reg};
    assign w_clamp = (width_reg == '0) ? 32'd1 :
                     (w_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_ext;
    assign w_eff   = w_clamp[CNT_W-1:0];
    assign h_eff   = (height_reg == '0) ? HGT_W'(1) :
                     (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;

    assign c_last   = ((CNT_W'(col_reg) + CNT_W'(1)) == w_eff);
    assign last_row = ((HGT_W'(row_reg) + HGT_W'(1)) == h_eff);
    assign accept   = push && !q_full;

    assign job_push           = accept;
    assign job_ctl.has_up     = (row_reg != '0);
    assign job_ctl.last_row   = last_row;
    assign job_ctl.has_right  = !c_last;
    assign job_ctl.self_rd    = (w_eff == CNT_W'(1));
    assign job_sample         = sample;
    assign job_row            = row_reg;
    assign job_col            = col_reg;
    assign job_addr           = c_last ? '0 : col_reg + COL_W'(1);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_next = cfg_data[HGT_W-1:0];
                default:    width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (c_last)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fgem_back.sv @@
// Back end: line buffer, gradient arithmetic and result presentation.
// Depends on fgem_pkg; drains the job queue.
`default_nettype none

module fgem_back #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W       = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_pop,
    input  fgem_pkg::job_ctl_t         job_ctl,
    input  logic [SAMPLE_BITS-1:0]     job_sample,
    input  logic [fgem_pkg::ROW_W-1:0] job_row,
    input  logic [COL_W-1:0]           job_col,
    input  logic [COL_W-1:0]           job_addr,
    output logic                       empty,
    input  logic                       pop,
    output logic [SAMPLE_BITS:0]       edge_value,
    output logic [fgem_pkg::ROW_W-1:0] pixel_row,
    output logic [COL_W-1:0]           pixel_col,
    output logic                       last_of_run
);

    import fgem_pkg::*;

    logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic [SAMPLE_BITS-1:0] carry_reg;
    job_ctl_t               ctl_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic                   valid_reg, valid_next;
    logic                   idx_reg, idx_next;

    logic [SAMPLE_BITS-1:0] above, right, diff_v, diff_h;
    logic [SAMPLE_BITS:0]   up_val;
    logic                   no_result, sel_up, last_res, retire, shown;

    assign above  = carry_reg;
    assign right  = rd_reg;
    assign diff_v = (sample_reg >= above) ? sample_reg - above : above - sample_reg;
    assign diff_h = (right >= above) ? right - above : above - right;
    assign up_val = ctl_reg.has_right ? ({1'b0, diff_v} + {1'b0, diff_h})
                                      : {1'b0, above};

    assign no_result = !ctl_reg.has_up && !ctl_reg.last_row;
    assign sel_up    = ctl_reg.has_up && !idx_reg;
    assign last_res  = idx_reg || !(ctl_reg.has_up && ctl_reg.last_row);
    assign empty     = !valid_reg || no_result;
    assign shown     = pop && !empty;
    assign retire    = valid_reg && (no_result || (shown && last_res));
    assign job_pop   = job_valid && (!valid_reg || retire);

    assign edge_value  = sel_up ? up_val : {1'b0, sample_reg};
    assign pixel_row   = sel_up ? row_reg - ROW_W'(1) : row_reg;
    assign pixel_col   = col_reg;
    assign last_of_run = sel_up ? !ctl_reg.last_row : 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (retire)
        begin
            valid_next = 1'b0;
            idx_next   = 1'b0;
        end
        else if (shown)
        begin
            idx_next = 1'b1;
        end
        if (job_pop)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            line_mem[job_col] <= job_sample;
            rd_reg            <= line_mem[job_addr];
            ctl_reg           <= job_ctl;
            sample_reg        <= job_sample;
            row_reg           <= job_row;
            col_reg           <= job_col;
        end
        if (retire)
        begin
            carry_reg <= ctl_reg.self_rd ? sample_reg : rd_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fgem_checker.sv @@
// Port-level checks on the edge map result channel, bound to the top level.
// Depends on fgem_pkg and forward_gradient_edge_map_macros.svh.
`default_nettype none

`include "forward_gradient_edge_map_macros.svh"

module fgem_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W       = 11
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [SAMPLE_BITS:0]       edge_value,
    input logic [fgem_pkg::ROW_W-1:0] pixel_row,
    input logic [COL_W-1:0]           pixel_col,
    input logic                       last_of_run
);

    import fgem_pkg::*;

    logic mid_run;

    assign mid_run = pop && !empty && !last_of_run;

    // the second result of an item follows straight away
    `FGEM_ASSERT_NEXT(a_run_follows, clk, rst_n, mid_run, !empty)

    // it is the pixel one row below, same column
    `FGEM_ASSERT_NEXT(a_run_pixel, clk, rst_n, mid_run,
        (pixel_col == $past(pixel_col)) &&
        (pixel_row == $past(pixel_row) + ROW_W'(1)))

    // the closing result is the unchanged sample, which fits the sample width
    `FGEM_ASSERT_NEXT(a_run_close, clk, rst_n, mid_run,
        last_of_run && !edge_value[SAMPLE_BITS])

    // a waiting result holds while not taken
    `FGEM_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(edge_value) && $stable(pixel_row) &&
        $stable(pixel_col) && $stable(last_of_run))

endmodule

bind forward_gradient_edge_map fgem_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       (COL_W)
) u_fgem_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .edge_value  (edge_value),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .last_of_run (last_of_run)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for the forward gradient edge map: random pushes and
// pops around a line-buffer predictor held in a small tracker class.
// Depends on fgem_pkg and forward_gradient_edge_map.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fgem_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 4096;
    localparam int SETTLE_CYCLE = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct packed {
        logic [16:0] value;
        logic [11:0] row;
        logic [10:0] col;
        logic        last_flag;
    } pixel_t;

    class edge_map_tracker;
        logic [WIDTH_REG_W-1:0] width_reg;
        logic [HGT_W-1:0]       height_reg;
        logic [15:0]            line_store [0:MAX_W-1];
        int unsigned            col;
        int unsigned            row;
        pixel_t                 pending_pixels [$];
        int                     errors;

        function void clear();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (line_store[i]) line_store[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
            pending_pixels.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WIDTH)
                width_reg = data[WIDTH_REG_W-1:0];
            else
                height_reg = data;
            col = 0;
            row = 0;
        endfunction

        function int unsigned gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void take_sample(logic [15:0] s);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned above;
            int unsigned val;
            bit          last_row;
            pixel_t      px;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > MAX_W) w = MAX_W;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > MAX_H) h = MAX_H;
            c = col;
            r = row;
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            last_row = (r + 1 == h);
            if (r > 0)
            begin
                above = line_store[c];
                if (c + 1 < w)
                    val = gap(s, above) + gap(line_store[c + 1], above);
                else
                    val = above;
                px.value     = val[16:0];
                px.row       = 12'(r - 1);
                px.col       = 11'(c);
                px.last_flag = !last_row;
                pending_pixels.push_back(px);
            end
            if (last_row)
            begin
                px.value     = {1'b0, s};
                px.row       = 12'(r);
                px.col       = 11'(c);
                px.last_flag = 1'b1;
                pending_pixels.push_back(px);
            end
            line_store[c] = s;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col = c;
            row = r;
        endfunction

        function void match_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item value %0d row %0d col %0d last %0b",
                         $time, got.value, got.row, got.col, got.last_flag);
                return;
            end
            want = pending_pixels.pop_front();
            if (got !== want)
            begin
                errors++;
                $display({"%0t: expected value %0d row %0d col %0d last %0b,",
                          " actual value %0d row %0d col %0d last %0b"},
                         $time, want.value, want.row, want.col, want.last_flag,
                         got.value, got.row, got.col, got.last_flag);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [15:0]          sample = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [16:0]          edge_value;
    logic [11:0]          pixel_row;
    logic [10:0]          pixel_col;
    logic                 last_of_run;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    edge_map_tracker tracker;
    int              burst_left;
    bit              sender_gaps;
    logic [15:0]     last_sample;
    logic [31:0]     pop_pattern;
    int unsigned     pop_cycle;
    int unsigned     cycle_count;
    int              random_items;
    int              n;
    int              ew;
    int              eh;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    pixel_t          got;

    forward_gradient_edge_map dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .edge_value  (edge_value),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("forward_gradient_edge_map verification failed");
                $finish;
            end
        end
    end

    // result side: check, then pick the next pop from the stall pattern
    initial
    begin
        pop_cycle = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.value     = edge_value;
                got.row       = pixel_row;
                got.col       = pixel_col;
                got.last_flag = last_of_run;
                tracker.match_pixel(got);
            end
            if (pop_cycle % 64 == 0)
                pop_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
            pop <= pop_pattern[pop_cycle % 32];
            pop_cycle++;
        end
    end

    function logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: pick_sample = 16'h0000;
            1: pick_sample = 16'hFFFF;
            2, 3: pick_sample = last_sample + 16'($urandom_range(0, 6)) - 16'd3;
            default: pick_sample = 16'($urandom);
        endcase
        last_sample = pick_sample;
    endfunction

    task automatic feed(input logic [15:0] s);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (sender_gaps)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full) @(posedge clk);
        tracker.take_sample(s);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLE) @(posedge clk);
    endtask

    task automatic load_regs(input bit [1:0] mask, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] h);
        if (mask[0])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_WIDTH;
            cfg_data  <= w;
            @(posedge clk);
            tracker.write_reg(REG_WIDTH, w);
        end
        if (mask[1])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_HEIGHT;
            cfg_data  <= h;
            @(posedge clk);
            tracker.write_reg(REG_HEIGHT, h);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic frame_section(input bit [1:0] mask, input logic [CFG_W-1:0] w,
                                 input logic [CFG_W-1:0] h, input int count);
        settle();
        load_regs(mask, w, h);
        sender_gaps = ($urandom_range(0, 3) != 0);
        burst_left  = 0;
        repeat (count) feed(pick_sample());
    endtask

    initial
    begin
        tracker = new();
        tracker.clear();
        last_sample = '0;
        burst_left  = 0;
        sender_gaps = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checkerboard of extremes in a 3x3 frame
        load_regs(2'b11, 13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            feed((i % 2 == 0) ? 16'h0000 : 16'hFFFF);
        frame_section(2'b11, 13'd4, 13'd1, 4);
        frame_section(2'b11, 13'd1, 13'd3, 3);
        frame_section(2'b11, 13'd3, 13'd3, 4);
        frame_section(2'b10, 13'd3, 13'd2, 6);

        // widest rows, tallest column, clamped register values
        frame_section(2'b11, 13'd2048, 13'd2, 40);
        frame_section(2'b11, 13'd0, 13'h1FFF, 40);
        frame_section(2'b11, 13'h1FFF, 13'd1, 40);
        frame_section(2'b11, 13'd5, 13'd0, 12);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 11))
                0: wv = '0;
                1: wv = 13'($urandom_range(17, 80));
                2: wv = 13'($urandom_range(2049, 8191));
                default: wv = 13'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0: hv = '0;
                1: hv = 13'($urandom_range(9, 20));
                default: hv = 13'($urandom_range(1, 8));
            endcase
            ew = (wv == 0) ? 1 : ((wv > MAX_W) ? MAX_W : int'(wv));
            eh = (hv == 0) ? 1 : int'(hv);
            n  = $urandom_range(1, 2 * ew * eh + ew);
            if (n > 150) n = $urandom_range(100, 150);
            frame_section(($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 2)) : 2'b11,
                          wv, hv, n);
            random_items += n;
        end

        settle();
        if (tracker.errors == 0)
            $display("forward_gradient_edge_map verification clean");
        else
            $display("forward_gradient_edge_map verification failed");
        $finish;
    end

endmodule

`default_nettype wire
